>>> rtl/core/hm8_pkg.sv
package hm8_pkg;

  localparam int PIX_W  = 8;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_REF   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SRC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_MAPPED = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BUILT  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_MAP_RD,
    S_MAP_ACC,
    S_MAP_MUL,
    S_MAP_WAIT,
    S_MT_SRC,
    S_MT_TGT,
    S_MT_RD,
    S_MT_SCAN,
    S_MT_START,
    S_MT_WAIT,
    S_PIX_RD,
    S_RESP
  } hm8_state_e;

endpackage

>>> rtl/core/hm8_div.sv
module hm8_div #(
  parameter int NW = 40,
  parameter int DW = 26,
  parameter int QW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int RW   = (NW > DW + QW) ? NW : DW + QW;
  localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   dsh_q;
  logic [QW-1:0]   quot_q;
  logic            fit;

  assign fit = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= RW'(num_i);
      dsh_q  <= RW'(den_i) << (QW - 1);
      cnt_q  <= CNTW'(QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fit) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= (quot_q << 1) | QW'(fit);
      dsh_q  <= dsh_q >> 1;
      cnt_q  <= cnt_q - CNTW'(1);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

endmodule

>>> rtl/core/histogram_matching_8bit_top.sv
// Histogram matching for one 8-bit gray channel.
// Input channel (in_valid_i/in_ready_o) carries kind_i and pixel_value_i;
// output channel (out_valid_o/out_ready_i) carries pixel_out_o and status_o.
// kind 0/1 count a reference/source pixel: the bin is read and written
// back one higher; no output word. kind 3 maps one pixel through the match
// table: the entry is read, then the output word is registered once the
// output slot is free, and only then is the next input taken.
// kind 2 builds the match table: two level maps, one level after another
// (one shared restoring divider, one quotient bit per cycle), then per
// source level a scan of the reference map and, on the same divider, a mean
// of the reference levels mapped to its target (else the first level mapped
// above it), then a histogram clear. An empty histogram only clears.
// After reset the block sweeps histograms and match table to zero with
// in_ready_o low.
// One output register holds a finished word; a new input is accepted while
// it waits, and a second word waits inside the block until the receiver
// takes the first.
module histogram_matching_8bit_top
  import hm8_pkg::*;
#(
  parameter int MAX_PIXELS = 16777216,
  parameter int LEVELS     = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [PIX_W-1:0]  pixel_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  pixel_out_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int CW   = $clog2(MAX_PIXELS + 1);
  localparam int LW   = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int SUMW = 2 * LW;
  localparam int NW   = (CW + LW + 1 > SUMW) ? CW + LW + 1 : SUMW;
  localparam int DW   = (CW + 1 > LW + 1) ? CW + 1 : LW + 1;
  localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PIXELS);

  hm8_state_e state_q, state_d;

  logic [LW-1:0]     i_q;
  logic              clr_all_q;
  logic [CW-1:0]     ref_tot_q, src_tot_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  pix_out_q;
  logic [STAT_W-1:0] status_q;

  logic [LW-1:0]     lvl_q;
  logic [KIND_W-1:0] kind_q;
  logic [STAT_W-1:0] resp_status_q;
  logic              sel_q;
  logic [CW-1:0]     cum_q;
  logic [LW-1:0]     r_q, target_q, larger_q;
  logic [SUMW-1:0]   sum_q;
  logic [LW:0]       n_q;

  logic [CW-1:0] hr_mem [LEVELS];
  logic [CW-1:0] hs_mem [LEVELS];
  logic [LW-1:0] mr_mem [LEVELS];
  logic [LW-1:0] ms_mem [LEVELS];
  logic [LW-1:0] mt_mem [LEVELS];
  logic [CW-1:0] hr_rd_q, hs_rd_q;
  logic [LW-1:0] mr_rd_q, ms_rd_q, mt_rd_q;

  logic          in_acc, slot_free, last_i, empty;
  logic [LW-1:0] lvl_in;
  logic [CW-1:0] tot_sel, h_sel, cum_d;
  logic [CW:0]   cum_sum;
  logic [LW-1:0] hist_ra, mr_ra;
  logic          hr_we, hs_we, mr_we, ms_we, mt_we;
  logic [CW-1:0] hr_wd, hs_wd;
  logic [LW-1:0] hist_wa, mt_wd;
  logic          div_start, div_done;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic [LW-1:0] div_quot;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_i     = (i_q == LAST);
  assign empty      = (ref_tot_q == '0) || (src_tot_q == '0);
  assign lvl_in     = (32'(pixel_value_i) >= LEVELS) ? LAST : LW'(pixel_value_i);
  assign tot_sel    = sel_q ? src_tot_q : ref_tot_q;
  assign h_sel      = sel_q ? hs_rd_q : hr_rd_q;
  assign cum_sum    = {1'b0, cum_q} + {1'b0, h_sel};
  assign cum_d      = (cum_sum >= {1'b0, tot_sel}) ? tot_sel : cum_sum[CW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (last_i) state_d = clr_all_q ? S_IDLE : S_RESP;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_REF, KIND_SRC: state_d = S_CNT_RD;
            KIND_BUILD:         state_d = empty ? S_CLEAR : S_MAP_RD;
            default:            state_d = S_PIX_RD;
          endcase
        end
      end
      S_CNT_RD:  state_d = S_CNT_WR;
      S_CNT_WR:  state_d = S_IDLE;
      S_MAP_RD:  state_d = S_MAP_ACC;
      S_MAP_ACC: state_d = S_MAP_MUL;
      S_MAP_MUL: state_d = S_MAP_WAIT;
      S_MAP_WAIT: begin
        if (div_done) state_d = (last_i && sel_q) ? S_MT_SRC : S_MAP_RD;
      end
      S_MT_SRC: state_d = S_MT_TGT;
      S_MT_TGT: state_d = S_MT_RD;
      S_MT_RD:  state_d = S_MT_SCAN;
      S_MT_SCAN: begin
        if ((target_q < mr_rd_q) || (r_q == LAST)) state_d = S_MT_START;
      end
      S_MT_START: state_d = S_MT_WAIT;
      S_MT_WAIT: begin
        if (div_done) state_d = last_i ? S_CLEAR : S_MT_SRC;
      end
      S_PIX_RD: state_d = S_RESP;
      S_RESP: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    hist_ra   = (state_q == S_CNT_RD) ? lvl_q : i_q;
    hist_wa   = (state_q == S_CLEAR) ? i_q : lvl_q;
    hr_we     = (state_q == S_CLEAR) || (state_q == S_CNT_WR && kind_q == KIND_REF);
    hs_we     = (state_q == S_CLEAR) || (state_q == S_CNT_WR && kind_q == KIND_SRC);
    hr_wd     = (state_q == S_CLEAR) ? '0 : ((hr_rd_q < MAXC) ? hr_rd_q + CW'(1) : hr_rd_q);
    hs_wd     = (state_q == S_CLEAR) ? '0 : ((hs_rd_q < MAXC) ? hs_rd_q + CW'(1) : hs_rd_q);
    mr_we     = (state_q == S_MAP_WAIT) && div_done && !sel_q;
    ms_we     = (state_q == S_MAP_WAIT) && div_done && sel_q;
    mr_ra     = (state_q == S_MT_SCAN && r_q != LAST) ? r_q + LW'(1) : r_q;
    mt_we     = ((state_q == S_MT_WAIT) && div_done) || (state_q == S_CLEAR && clr_all_q);
    mt_wd     = (state_q == S_CLEAR) ? '0 : div_quot;
    div_start = (state_q == S_MAP_MUL) || (state_q == S_MT_START);
    if (state_q == S_MAP_MUL) begin
      div_num = NW'(cum_q) * NW'(2 * (LEVELS - 1)) + NW'(tot_sel);
      div_den = DW'({tot_sel, 1'b0});
    end else if (n_q == '0) begin
      div_num = NW'(larger_q);
      div_den = DW'(1);
    end else begin
      div_num = NW'(sum_q);
      div_den = DW'(n_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hr_we) hr_mem[hist_wa] <= hr_wd;
    hr_rd_q <= hr_mem[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hs_we) hs_mem[hist_wa] <= hs_wd;
    hs_rd_q <= hs_mem[hist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mr_we) mr_mem[i_q] <= div_quot;
    mr_rd_q <= mr_mem[mr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ms_we) ms_mem[i_q] <= div_quot;
    ms_rd_q <= ms_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (mt_we) mt_mem[i_q] <= mt_wd;
    mt_rd_q <= mt_mem[lvl_q];
  end

  hm8_div #(
    .NW (NW),
    .DW (DW),
    .QW (LW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      i_q         <= '0;
      clr_all_q   <= 1'b1;
      ref_tot_q   <= '0;
      src_tot_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_CLEAR) ||
          ((state_q == S_MAP_WAIT || state_q == S_MT_WAIT) && div_done)) begin
        i_q <= last_i ? '0 : i_q + LW'(1);
      end
      if (state_q == S_CLEAR) begin
        ref_tot_q <= '0;
        src_tot_q <= '0;
        if (last_i) clr_all_q <= 1'b0;
      end else if (in_acc && kind_i == KIND_REF && ref_tot_q < MAXC) begin
        ref_tot_q <= ref_tot_q + CW'(1);
      end else if (in_acc && kind_i == KIND_SRC && src_tot_q < MAXC) begin
        src_tot_q <= src_tot_q + CW'(1);
      end
      if (state_q == S_RESP && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lvl_q         <= lvl_in;
      kind_q        <= kind_i;
      resp_status_q <= empty ? STATUS_EMPTY : STATUS_BUILT;
      sel_q         <= 1'b0;
      cum_q         <= '0;
    end
    if (state_q == S_MAP_ACC) cum_q <= cum_d;
    if (state_q == S_MAP_WAIT && div_done && last_i) begin
      sel_q <= 1'b1;
      cum_q <= '0;
    end
    if (state_q == S_MT_TGT) begin
      target_q <= ms_rd_q;
      r_q      <= '0;
      sum_q    <= '0;
      n_q      <= '0;
      larger_q <= '0;
    end
    if (state_q == S_MT_SCAN) begin
      if (mr_rd_q == target_q) begin
        sum_q <= sum_q + SUMW'(r_q);
        n_q   <= n_q + (LW+1)'(1);
      end
      if (target_q < mr_rd_q) larger_q <= r_q;
      if (r_q != LAST) r_q <= r_q + LW'(1);
    end
    if (state_q == S_RESP && slot_free) begin
      pix_out_q <= (kind_q == KIND_MAP) ? PIX_W'(mt_rd_q) : '0;
      status_q  <= (kind_q == KIND_MAP) ? STATUS_MAPPED : resp_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_out_q;
  assign status_o    = status_q;

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_quot <= LAST)) else $error("quotient beyond top level");

  a_cum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAP_MUL) |-> (cum_q <= tot_sel)) else $error("cumulative count above total");

  a_map_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_MAP) |-> ##2 (state_q == S_RESP))
    else $error("map word not ready on time");

  a_mean_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MT_START) |-> (n_q <= (LW+1)'(LEVELS))) else $error("match count overflow");

endmodule
